FILE: src/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared widths and types for the trial division prime test core.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int CAND_W = 32;
    localparam int DIV_W  = CAND_W / 2 + 1;
    localparam int SQ_W   = 2 * DIV_W;
    localparam int CNT_W  = $clog2(CAND_W);

    typedef struct packed {
        logic start;
    } mod_ctrl_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } mod_stat_t;

endpackage

FILE: src/tdpt_mod_unit.sv
// ----------------------------------------------------------------------------
// tdpt_mod_unit
// Bit-serial restoring modulo: one candidate bit per cycle into the remainder.
// ----------------------------------------------------------------------------
module tdpt_mod_unit
    import tdpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mod_ctrl_t         ctrl,
    input  logic [CAND_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output mod_stat_t         stat
);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [CAND_W-1:0] shift_reg, shift_next;
    logic [DIV_W-1:0]  div_reg,   div_next;
    logic [DIV_W-1:0]  rem_reg,   rem_next;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        trial      = {rem_reg, shift_reg[CAND_W-1]};
        diff       = trial - {1'b0, div_reg};
        if (ctrl.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            div_next   = divisor;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[CAND_W-2:0], 1'b0};
            if (!diff[DIV_W])
                rem_next = diff[DIV_W-1:0];
            else
                rem_next = trial[DIV_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CAND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

FILE: src/trial_division_prime_test_core.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_core
// Primality test of a 32-bit candidate by trial division with odd divisors.
// ----------------------------------------------------------------------------
// One candidate is tested at a time. The divisors 3, 5, 7, ... are tried while
// d*d <= candidate; each tried divisor takes one bound check, a bit-serial
// modulo over the 32 candidate bits and a read of its remainder. A verdict
// waits in ST_FIN until the output register is free. The bound d*d is kept as
// a running square. The result sits in an output register, so the next
// candidate is taken while it waits.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core
    import tdpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CAND_W-1:0] candidate,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              is_prime
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]        state_reg,  state_next;
    logic              ovalid_reg, ovalid_next;
    logic              oprime_reg, oprime_next;
    logic              res_reg,    res_next;
    logic [CAND_W-1:0] n_reg,      n_next;
    logic [DIV_W-1:0]  d_reg,      d_next;
    logic [SQ_W-1:0]   sq_reg,     sq_next;
    mod_ctrl_t         mctrl;
    mod_stat_t         mstat;

    tdpt_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mctrl),
        .dividend (n_reg),
        .divisor  (d_reg),
        .stat     (mstat)
    );

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        oprime_next = oprime_reg;
        res_next    = res_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        sq_next     = sq_reg;
        mctrl.start = 1'b0;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next     = candidate;
                    d_next     = DIV_W'(3);
                    sq_next    = SQ_W'(9);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sq_reg > SQ_W'(n_reg))
                begin
                    res_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    mctrl.start = 1'b1;
                    state_next  = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (mstat.done)
                begin
                    if (mstat.rem_zero)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        d_next     = d_reg + DIV_W'(2);
                        sq_next    = sq_reg + SQ_W'({d_reg, 2'b00}) + SQ_W'(4);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FIN:
            begin
                if (!ovalid_next)
                begin
                    ovalid_next = 1'b1;
                    oprime_next = res_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oprime_reg <= oprime_next;
        res_reg    <= res_next;
        n_reg      <= n_next;
        d_reg      <= d_next;
        sq_reg     <= sq_next;
    end

    assign out_valid = ovalid_reg;
    assign is_prime  = oprime_reg;

endmodule

FILE: verif/tb_trial_division_prime_test_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trial_division_prime_test_core
// Self-checking testbench for the trial division prime test core.
// ----------------------------------------------------------------------------
// Candidates go in over a valid/ready channel in random bursts while the
// result channel stalls on its own pattern. A scoreboard computes the
// verdict of every accepted candidate by odd trial division and checks each
// result transaction against the oldest pending verdict. Most candidates
// are small to keep run time bounded; large ones carry a small odd factor.
// ----------------------------------------------------------------------------
module tb_trial_division_prime_test_core
    import tdpt_pkg::*;
();

    localparam int NUM_RANDOM   = 100;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 100;

    class prime_scoreboard;
        bit expected_verdicts[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        function bit trial_division_verdict(logic [CAND_W-1:0] value);
            longint unsigned n;
            longint unsigned d;
            bit prime;
            n = value;
            d = 3;
            prime = 1'b1;
            while (prime && (d <= n / d))
            begin
                if (n % d == 0)
                    prime = 1'b0;
                else
                    d += 2;
            end
            return prime;
        endfunction

        function void note_candidate(logic [CAND_W-1:0] value);
            expected_verdicts.push_back(trial_division_verdict(value));
        endfunction

        function void check_result(logic got);
            bit want;
            if (expected_verdicts.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result transaction: is_prime=%0b", got);
                mismatches++;
                return;
            end
            want = expected_verdicts.pop_front();
            if (got !== want)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("is_prime mismatch: expected %0b actual %0b", want, got);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [CAND_W-1:0] candidate;
    logic              out_valid;
    logic              out_ready;
    logic              is_prime;

    prime_scoreboard sb;
    int burst_left;

    trial_division_prime_test_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .candidate (candidate),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_prime  (is_prime)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_candidate(candidate);
            if (out_valid && out_ready)
                sb.check_result(is_prime);
        end
    end

    // result side back-pressure
    initial
    begin
        int len;
        int mode;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            len  = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            repeat (len)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_ready <= 1'b0;
                    2:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_candidate(input logic [CAND_W-1:0] value);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 20));
        end
        burst_left--;
        candidate <= value;
        in_valid  <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [CAND_W-1:0] large_composite();
        logic [CAND_W-1:0] r;
        logic [CAND_W-1:0] f;
        logic [CAND_W-1:0] n;
        r = $urandom;
        if ($urandom_range(0, 1))
            r = r | 32'h8000_0001;
        case ($urandom_range(0, 4))
            0:       f = 3;
            1:       f = 5;
            2:       f = 7;
            3:       f = 11;
            default: f = 13;
        endcase
        n = r - (r % f);
        if (r[0] && !n[0] && n >= f)
            n = n - f;
        return n;
    endfunction

    initial
    begin
        logic [CAND_W-1:0] directed [$];
        logic [CAND_W-1:0] value;
        int sel;

        sb = new();
        burst_left = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        candidate <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7,
                     32'd8, 32'd9, 32'd15, 32'd25, 32'd27, 32'd49, 32'd121,
                     32'd169, 32'd65537, 32'd1000003, 32'hFFFF_FFFF,
                     32'h8000_0001, 32'hC000_0000, 32'hAAAA_AAAA};
        foreach (directed[i])
            send_candidate(directed[i]);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 17)
            begin
                if (sel < 12)
                    value = $urandom_range(0, 4095);
                else
                    value = $urandom_range(0, 20'hF_FFFF);
                if ($urandom_range(0, 1))
                    value[0] = 1'b1;
            end
            else
                value = large_composite();
            send_candidate(value);
        end
        idle_cycles(1);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: trial_division_prime_test_core.f
src/tdpt_pkg.sv
src/tdpt_mod_unit.sv
src/trial_division_prime_test_core.sv
verif/tb_trial_division_prime_test_core.sv
